>>> rtl/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Shared types, default sizes and counter update functions.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int ADDR_FIELD_W  = 4;
	localparam int ADDR_BITS_DEF = 4;
	localparam int HIST_BITS_DEF = 6;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_RESET = 2'd0;
	localparam ctr_t CTR_MAX   = 2'd3;
	localparam ctr_t CTR_MIN   = 2'd0;

	// A 2-bit counter moves one step toward the outcome and saturates.
	function automatic ctr_t sat_step(input ctr_t v, input logic up);
		ctr_t r;
		r = v;
		if (up) begin
			if (v != CTR_MAX) r = v + 2'd1;
		end else begin
			if (v != CTR_MIN) r = v - 2'd1;
		end
		return r;
	endfunction

	// The chooser moves toward whichever predictor alone was right.
	function automatic ctr_t chooser_step(input ctr_t v, input logic local_ok,
			input logic global_ok);
		ctr_t r;
		r = v;
		if (global_ok && !local_ok) r = sat_step(v, 1'b1);
		else if (local_ok && !global_ok) r = sat_step(v, 1'b0);
		return r;
	endfunction

endpackage

>>> rtl/tbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor channel interfaces
// Valid/ready channels for resolved branches and prediction results.
// ----------------------------------------------------------------------------
interface tbp_branch_if;
	logic                            valid;
	logic                            ready;
	logic [tbp_pkg::ADDR_FIELD_W-1:0] branch_address;
	logic                            taken;

	modport source(output valid, output branch_address, output taken, input ready);
	modport sink(input valid, input branch_address, input taken, output ready);
endinterface

interface tbp_result_if;
	logic                            valid;
	logic                            ready;
	logic [tbp_pkg::ADDR_FIELD_W-1:0] address_echo;
	logic                            local_guess;
	logic                            global_guess;
	logic                            use_global;
	logic                            final_guess;

	modport source(output valid, output address_echo, output local_guess,
		output global_guess, output use_global, output final_guess, input ready);
	modport sink(input valid, input address_echo, input local_guess,
		input global_guess, input use_global, input final_guess, output ready);
endinterface

>>> rtl/tbp_ctr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counter table memory
// Synchronous table of 2-bit counters with a registered read port. Per-entry
// valid bits make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module tbp_ctr_mem #(
	parameter int IDX_BITS = tbp_pkg::ADDR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_BITS-1:0] rd_idx,
	output tbp_pkg::ctr_t       rd_data,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_idx,
	input  tbp_pkg::ctr_t       wr_data
);
	import tbp_pkg::*;

	localparam int DEPTH = 1 << IDX_BITS;

	ctr_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	ctr_t             rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_idx] <= 1'b1;
			if (rd_en) rd_vld_q <= vld_q[rd_idx];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : CTR_RESET;

endmodule

>>> rtl/tournament_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local, global-history and chooser tables of 2-bit counters. Each resolved
// branch reports the predictions made from the old counters, then trains them.
// ----------------------------------------------------------------------------
// Pipeline: an accepted branch waits in stage s1, then its result moves into
// the result register once the output can take it. Throughput: one branch per
// cycle unless the output stalls; tables are read at accept and written back
// as the branch leaves s1, bypassed when consecutive branches hit one entry.
// Reset: asynchronous; all counters read as zero and the history is cleared.
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
	parameter int ADDR_BITS = tbp_pkg::ADDR_BITS_DEF,
	parameter int HIST_BITS = tbp_pkg::HIST_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	tbp_branch_if.sink          branch,
	tbp_result_if.source        result
);
	import tbp_pkg::*;

	logic                    accept;
	logic                    advance;
	logic [ADDR_BITS-1:0]    lidx_in;
	logic [HIST_BITS-1:0]    hist_q;

	logic                    valid_s1;
	logic [ADDR_FIELD_W-1:0] addr_s1;
	logic [ADDR_BITS-1:0]    lidx_s1;
	logic [HIST_BITS-1:0]    hidx_s1;
	logic                    taken_s1;
	logic                    lbyp_s1;
	logic                    gbyp_s1;
	ctr_t                    lbyp_val_s1;
	ctr_t                    cbyp_val_s1;
	ctr_t                    gbyp_val_s1;

	ctr_t l_rd, g_rd, c_rd;
	ctr_t lc, gc, cc;
	ctr_t l_new, g_new, c_new;
	logic lg, gg, ug, fg;

	logic                    res_valid_q;
	logic [ADDR_FIELD_W-1:0] res_addr_q;
	logic                    res_lg_q;
	logic                    res_gg_q;
	logic                    res_ug_q;
	logic                    res_fg_q;

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign branch.ready = !valid_s1 || advance;
	assign accept       = branch.valid && branch.ready;
	assign lidx_in      = ADDR_BITS'(branch.branch_address);

	tbp_ctr_mem #(.IDX_BITS(ADDR_BITS)) u_local (
		.clk(clk), .arst_n(arst_n),
		.rd_en(accept), .rd_idx(lidx_in), .rd_data(l_rd),
		.wr_en(advance), .wr_idx(lidx_s1), .wr_data(l_new)
	);

	tbp_ctr_mem #(.IDX_BITS(ADDR_BITS)) u_chooser (
		.clk(clk), .arst_n(arst_n),
		.rd_en(accept), .rd_idx(lidx_in), .rd_data(c_rd),
		.wr_en(advance), .wr_idx(lidx_s1), .wr_data(c_new)
	);

	tbp_ctr_mem #(.IDX_BITS(HIST_BITS)) u_global (
		.clk(clk), .arst_n(arst_n),
		.rd_en(accept), .rd_idx(hist_q), .rd_data(g_rd),
		.wr_en(advance), .wr_idx(hidx_s1), .wr_data(g_new)
	);

	// A read issued in the same cycle as a write-back to the same entry sees
	// the old value, so the freshly written counter is forwarded instead.
	always_comb begin
		lc    = lbyp_s1 ? lbyp_val_s1 : l_rd;
		cc    = lbyp_s1 ? cbyp_val_s1 : c_rd;
		gc    = gbyp_s1 ? gbyp_val_s1 : g_rd;
		lg    = lc[1];
		gg    = gc[1];
		ug    = cc[1];
		fg    = ug ? gg : lg;
		l_new = sat_step(lc, taken_s1);
		g_new = sat_step(gc, taken_s1);
		c_new = chooser_step(cc, lg == taken_s1, gg == taken_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				hist_q   <= HIST_BITS'({hist_q, branch.taken});
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= branch.branch_address;
			lidx_s1     <= lidx_in;
			hidx_s1     <= hist_q;
			taken_s1    <= branch.taken;
			lbyp_s1     <= advance && (lidx_s1 == lidx_in);
			gbyp_s1     <= advance && (hidx_s1 == hist_q);
			lbyp_val_s1 <= l_new;
			cbyp_val_s1 <= c_new;
			gbyp_val_s1 <= g_new;
		end
		if (advance) begin
			res_addr_q <= addr_s1;
			res_lg_q   <= lg;
			res_gg_q   <= gg;
			res_ug_q   <= ug;
			res_fg_q   <= fg;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.address_echo = res_addr_q;
	assign result.local_guess  = res_lg_q;
	assign result.global_guess = res_gg_q;
	assign result.use_global   = res_ug_q;
	assign result.final_guess  = res_fg_q;

endmodule

>>> rtl/tbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor checker
// Port-level assertions on stalling, result latency and result consistency.
// ----------------------------------------------------------------------------
module tbp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_local_guess,
	input logic out_global_guess,
	input logic out_use_global,
	input logic out_final_guess
);

	// A held result must stay offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped before it was taken");

	// The input only stalls while a finished result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// An accepted branch reaches the output if the output does not block it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result missing two cycles after transaction");

	// The final guess follows the chooser.
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_final_guess ==
			(out_use_global ? out_global_guess : out_local_guess))
		else $error("final guess does not follow chooser");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(branch.valid),
	.in_ready(branch.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_local_guess(result.local_guess),
	.out_global_guess(result.global_guess),
	.out_use_global(result.use_global),
	.out_final_guess(result.final_guess)
);
